// ----- hw/rtl/sm3_pkg.sv -----
package sm3_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        final_word;
	} sm3_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_of_digest;
	} sm3_out_t;

	// Item passed from the front to the back: data word, its clamped byte count and final flag
	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        final_word;
	} sm3_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} sm3_state_t;

	localparam logic [31:0] TCONST_LO = 32'h79cc4519;
	localparam logic [31:0] TCONST_HI = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE  = 8'h80;
	localparam int          QDEPTH    = 2;

	localparam logic [255:0] INIT_VALUE = {
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

// ----- hw/rtl/sm3_front.sv -----
module sm3_front import sm3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  sm3_in_t  in_data,
	output logic     q_valid,
	input  logic     q_pop,
	output sm3_cmd_t q_data
);

	sm3_cmd_t    mem_q [QDEPTH];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	sm3_cmd_t    cmd;

	// Clamp oversized byte counts
	always_comb begin
		cmd = in_data;
		if (in_data.byte_count > 3'd4) begin
			cmd.byte_count = 3'd4;
		end
	end

	assign in_stall = (cnt_q == 2'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ----- hw/rtl/sm3_back.sv -----
module sm3_back import sm3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	output logic     q_pop,
	input  sm3_cmd_t q_data,
	output logic     out_valid,
	input  logic     out_stall,
	output sm3_out_t out_data
);

	sm3_state_t  state_q, state_d;
	logic [31:0] blk_q [16];
	logic [31:0] cv_q [8];
	logic [31:0] r_q [8];
	logic [5:0]  fill_q;
	logic [63:0] total_q;
	logic [6:0]  rnd_q;
	logic [2:0]  bidx_q;
	logic [3:0]  padidx_q;
	logic [2:0]  oidx_q;
	sm3_cmd_t    cur_q;

	// Current byte to insert
	logic [7:0]  byte_b;
	logic        byte_go;
	logic [63:0] bits;
	logic        blk_full;

	assign bits     = {total_q[60:0], 3'b000};
	assign blk_full = (fill_q == 6'd63);

	always_comb begin
		byte_b  = 8'd0;
		byte_go = 1'b0;
		case (state_q)
			ST_BYTE: begin
				byte_b  = cur_q.data_word[5'd31 - {bidx_q[1:0], 3'b000} -: 8];
				byte_go = (bidx_q < cur_q.byte_count);
			end
			ST_PAD: begin
				byte_go = 1'b1;
				if (padidx_q == 4'd0) begin
					byte_b = PAD_BYTE;
				end else if (padidx_q == 4'd1) begin
					byte_b = 8'd0;
				end else begin
					byte_b = bits[6'd63 - {padidx_q[2:0] - 3'd2, 3'b000} -: 8];
				end
			end
			default: ;
		endcase
	end

	// Round datapath
	logic [31:0] w_j, w_j4, wnew, tc, a12, s1, s2, fa, fe, t1, t2;
	logic        early;
	assign early = (rnd_q < 7'd16);
	assign w_j   = blk_q[0];
	assign w_j4  = blk_q[4];
	assign wnew  = perm1(blk_q[0] ^ blk_q[7] ^ rotl(blk_q[13], 5'd15))
	               ^ rotl(blk_q[3], 5'd7) ^ blk_q[10];
	assign tc    = early ? TCONST_LO : TCONST_HI;
	assign a12   = rotl(r_q[0], 5'd12);
	assign s1    = rotl(a12 + r_q[4] + rotl(tc, rnd_q[4:0]), 5'd7);
	assign s2    = s1 ^ a12;
	assign fa    = early ? (r_q[0] ^ r_q[1] ^ r_q[2])
	             : ((r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]));
	assign fe    = early ? (r_q[4] ^ r_q[5] ^ r_q[6])
	             : ((r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]));
	assign t1    = fa + r_q[3] + s2 + (w_j ^ w_j4);
	assign t2    = fe + r_q[7] + s1 + w_j;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_BYTE;
			ST_BYTE: begin
				if (byte_go && blk_full) state_d = ST_COMP;
				else if (bidx_q >= cur_q.byte_count || (byte_go && bidx_q == 3'd3))
					state_d = cur_q.final_word ? ST_PAD : ST_IDLE;
			end
			ST_PAD: if (blk_full) state_d = ST_COMP;
			ST_COMP: begin
				if (rnd_q == 7'd63) begin
					if (padidx_q == 4'd10) state_d = ST_OUT;
					else if (padidx_q != 4'd0) state_d = ST_PAD;
					else if (bidx_q > 3'd3 || bidx_q >= cur_q.byte_count)
						state_d = cur_q.final_word ? ST_PAD : ST_IDLE;
					else state_d = ST_BYTE;
				end
			end
			ST_OUT: if (!out_stall && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		q_pop     = (state_q == ST_IDLE) && q_valid;
		out_valid = (state_q == ST_OUT);
		out_data.digest_word    = cv_q[oidx_q];
		out_data.word_index     = oidx_q;
		out_data.last_of_digest = (oidx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Control counters and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 6'd0;
			total_q  <= 64'd0;
			rnd_q    <= 7'd0;
			bidx_q   <= 3'd0;
			padidx_q <= 4'd0;
			oidx_q   <= 3'd0;
			for (int i = 0; i < 8; i++) cv_q[i] <= INIT_VALUE[255 - 32*i -: 32];
		end else begin
			case (state_q)
				ST_IDLE: begin
					bidx_q   <= 3'd0;
					padidx_q <= 4'd0;
					oidx_q   <= 3'd0;
				end
				ST_BYTE: if (byte_go) begin
					fill_q  <= fill_q + 6'd1;
					total_q <= total_q + 64'd1;
					bidx_q  <= bidx_q + 3'd1;
				end else begin
					bidx_q <= 3'd4;
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					// no zero bytes when the marker lands just before the length
					if (padidx_q == 4'd0) padidx_q <= (fill_q == 6'd55) ? 4'd2 : 4'd1;
					else if (padidx_q == 4'd1) begin
						if (fill_q == 6'd55) padidx_q <= 4'd2;
					end else padidx_q <= padidx_q + 4'd1;
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
					// fold in the working registers as they leave the last round
					if (rnd_q == 7'd63) begin
						rnd_q   <= 7'd0;
						cv_q[0] <= cv_q[0] ^ t1;
						cv_q[1] <= cv_q[1] ^ r_q[0];
						cv_q[2] <= cv_q[2] ^ rotl(r_q[1], 5'd9);
						cv_q[3] <= cv_q[3] ^ r_q[2];
						cv_q[4] <= cv_q[4] ^ perm0(t2);
						cv_q[5] <= cv_q[5] ^ r_q[4];
						cv_q[6] <= cv_q[6] ^ rotl(r_q[5], 5'd19);
						cv_q[7] <= cv_q[7] ^ r_q[6];
					end
				end
				ST_OUT: if (!out_stall) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						fill_q  <= 6'd0;
						total_q <= 64'd0;
						for (int i = 0; i < 8; i++)
							cv_q[i] <= INIT_VALUE[255 - 32*i -: 32];
					end
				end
				default: ;
			endcase
		end
	end

	// Block buffer (shifts during compression as expansion window), work regs
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) cur_q <= q_data;
		if (byte_go && (state_q == ST_BYTE || state_q == ST_PAD)) begin
			if (fill_q[1:0] == 2'd0)
				blk_q[fill_q[5:2]] <= {byte_b, 24'd0};
			else
				blk_q[fill_q[5:2]][5'd31 - {fill_q[1:0], 3'b000} -: 8] <= byte_b;
			if (blk_full)
				for (int i = 0; i < 8; i++) r_q[i] <= cv_q[i];
		end
		if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
			blk_q[15] <= wnew;
			r_q[3] <= r_q[2];
			r_q[2] <= rotl(r_q[1], 5'd9);
			r_q[1] <= r_q[0];
			r_q[0] <= t1;
			r_q[7] <= r_q[6];
			r_q[6] <= rotl(r_q[5], 5'd19);
			r_q[5] <= r_q[4];
			r_q[4] <= perm0(t2);
		end
	end

endmodule

// ----- hw/rtl/sm3_hash_engine.sv -----
// SM3 hash engine, 256-bit digest.
// Input channel in_valid/in_stall/in_data carries big-endian message words,
// each with byte_count leading valid bytes (values above 4 count as 4) and
// final_word marking the end of the message. A transfer on the output channel
// out_valid/out_stall/out_data moves one digest word; eight follow a final word,
// index 0 first, the eighth flagged last_of_digest.
// A two-entry queue parts the input from the byte packer and compression core,
// so up to two words are taken while the core is busy.
// The packer fetches each word from the queue, then inserts its valid bytes
// one per cycle; a short word takes a further step to close. Each full
// 64-byte block is then compressed, one compression round per cycle, and byte
// insertion waits while it runs. Padding runs one byte per cycle, also paused
// by compression. The first digest word is offered in the cycle after the last
// round and each word is held while out_stall is high; no new word leaves the
// queue until the whole digest is taken.
// Reset clears the queue, counters and loads the SM3 initial value; the block
// buffer is not cleared.
module sm3_hash_engine import sm3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  sm3_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output sm3_out_t out_data
);

	logic     q_valid, q_pop;
	sm3_cmd_t q_data;

	sm3_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_valid, .q_pop, .q_data
	);

	sm3_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data,
		.out_valid, .out_stall, .out_data
	);

endmodule
